### hw/rtl/ncc_pkg.sv
package ncc_pkg;

    localparam int PIX_W  = 8;
    localparam int WT_W   = 8;
    localparam int PROD_W = WT_W + PIX_W + 1;
    localparam int ACC_W  = 20;
    localparam int TOT_W  = 12;
    localparam int QUO_W  = ACC_W - 1;
    localparam int DVS_W  = TOT_W - 1;
    localparam int CFG_W  = 24;
    localparam int SIZE_W = 10;
    localparam int IDX_W  = 3;
    localparam int TAP_W  = 4;
    localparam int MIN_DIM = 3;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(8);
    localparam logic [PIX_W-1:0] PIX_MAX  = PIX_W'(255);

    localparam logic [IDX_W-1:0] REG_WEIGHTS_TOP    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_WEIGHTS_MIDDLE = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_WEIGHTS_BOTTOM = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = IDX_W'(4);

    localparam logic [CFG_W-1:0]  RST_WEIGHTS_TOP    = CFG_W'(24'hFE0000);
    localparam logic [CFG_W-1:0]  RST_WEIGHTS_MIDDLE = CFG_W'(24'hFE0BFE);
    localparam logic [CFG_W-1:0]  RST_WEIGHTS_BOTTOM = CFG_W'(24'hFE0000);
    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH    = SIZE_W'(300);
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT   = SIZE_W'(168);

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] acc;
        logic signed [TOT_W-1:0] total;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] value;
    } t_div_rsp;

endpackage

### hw/rtl/normalized_3x3_convolution_clamp_unit.sv
// channel   direction  payload (lowest bit first)           handshake
// s_axis    in         tdata: pixel_in                       tvalid / tready
// m_axis    out        tdata: filtered_value, tlast: row_end,
//                      tuser: frame_end                      tvalid / tready
// cfg       in         i_cfg_data by i_cfg_index             i_cfg_we, no wait
//
// a border pixel is only accepted and loaded (line store read, window update and write back)
// an interior pixel passes accept, load, a 9-step multiply-accumulate on one multiplier,
// the 19-step restoring divider and its done strobe, then the output register
// with a zero weight sum the divider skips the restoring steps and answers with the clamped raw sum
// after reset every line store address is cleared with s_axis_tready low
// a finished result waits in the output register; the next request is taken meanwhile,
// and the following result holds in push until that register drains
module normalized_3x3_convolution_clamp_unit
    import ncc_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIX_W-1:0]   s_axis_tdata,   // pixel_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PIX_W-1:0]   m_axis_tdata,   // filtered_value
    output logic               m_axis_tlast,   // row_end
    output logic               m_axis_tuser,   // frame_end
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CMPC_W = (SIZE_W > COL_W + 1) ? SIZE_W : COL_W + 1;
    localparam int CMPR_W = (SIZE_W > ROW_W + 1) ? SIZE_W : ROW_W + 1;
    localparam int LS_W   = 2 * PIX_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DIV,
        ST_PUSH
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]  r_wt_top;
    logic [CFG_W-1:0]  r_wt_mid;
    logic [CFG_W-1:0]  r_wt_bot;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    logic [COL_W-1:0]  r_clr_addr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_c;
    logic [PIX_W-1:0]  r_px;
    logic              r_interior;
    logic              r_last_col;
    logic              r_last_row;
    logic [PIX_W-1:0]  r_win [9];
    logic [TAP_W-1:0]  r_k;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [TOT_W-1:0] r_tot;
    logic [PIX_W-1:0]  r_res;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_data;
    logic              r_out_last;
    logic              r_out_user;

    logic [CMPC_W-1:0] w_width_ext;
    logic [CMPR_W-1:0] w_height_ext;
    logic [COL_W-1:0]  w_col_last;
    logic [ROW_W-1:0]  w_row_last;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;
    logic              w_last_col;
    logic              w_last_row;
    logic              w_accept;

    logic              w_ram_we;
    logic [COL_W-1:0]  w_ram_waddr;
    logic [LS_W-1:0]   w_ram_wdata;
    logic [LS_W-1:0]   w_ram_rdata;

    logic [3*CFG_W-1:0]       w_wts;
    logic signed [WT_W-1:0]   w_wt;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [TOT_W-1:0]  n_tot;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // frame size bounded to 3..MAX
    assign w_width_ext  = CMPC_W'(r_width);
    assign w_height_ext = CMPR_W'(r_height);
    assign w_col_last = (w_width_ext < CMPC_W'(MIN_DIM)) ? COL_W'(MIN_DIM - 1) :
                        (w_width_ext > CMPC_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1) :
                        COL_W'(w_width_ext - CMPC_W'(1));
    assign w_row_last = (w_height_ext < CMPR_W'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1) :
                        (w_height_ext > CMPR_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT - 1) :
                        ROW_W'(w_height_ext - CMPR_W'(1));

    assign w_last_col = (r_col >= w_col_last);
    assign w_last_row = (r_row >= w_row_last);
    assign w_col      = w_last_col ? w_col_last : r_col;
    assign w_row      = w_last_row ? w_row_last : r_row;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // line store: upper row in high byte, lower row in low byte
    assign w_ram_we    = (r_state == ST_CLEAR) || (r_state == ST_LOAD);
    assign w_ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_c;
    assign w_ram_wdata = (r_state == ST_CLEAR) ? '0 : {w_ram_rdata[PIX_W-1:0], r_px};

    ncc_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_col),
        .o_rdata (w_ram_rdata)
    );

    // one tap per cycle
    assign w_wts  = {r_wt_bot, r_wt_mid, r_wt_top};
    assign w_wt   = w_wts[{r_k, 3'b000} +: WT_W];
    assign w_prod = w_wt * $signed({1'b0, r_win[r_k]});
    assign n_acc  = r_acc + {{(ACC_W - PROD_W){w_prod[PROD_W-1]}}, w_prod};
    assign n_tot  = r_tot + {{(TOT_W - WT_W){w_wt[WT_W-1]}}, w_wt};

    assign w_div_req.start = (r_state == ST_MAC) && (r_k == TAP_LAST);
    assign w_div_req.acc   = n_acc;
    assign w_div_req.total = n_tot;

    ncc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt_top <= RST_WEIGHTS_TOP;
            r_wt_mid <= RST_WEIGHTS_MIDDLE;
            r_wt_bot <= RST_WEIGHTS_BOTTOM;
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WEIGHTS_TOP:    r_wt_top <= i_cfg_data;
                REG_WEIGHTS_MIDDLE: r_wt_mid <= i_cfg_data;
                REG_WEIGHTS_BOTTOM: r_wt_bot <= i_cfg_data;
                REG_IMAGE_WIDTH:    r_width  <= i_cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:   r_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != ST_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + COL_W'(1);
                    if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_px       <= s_axis_tdata;
                        r_c        <= w_col;
                        r_interior <= (w_col >= COL_W'(2)) && (w_row >= ROW_W'(2));
                        r_last_col <= w_last_col;
                        r_last_row <= w_last_row;
                        if (w_last_col) begin
                            r_col <= '0;
                            r_row <= w_last_row ? '0 : w_row + ROW_W'(1);
                        end else begin
                            r_col <= w_col + COL_W'(1);
                            r_row <= w_row;
                        end
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    for (int y = 0; y < 3; y++) begin
                        r_win[3*y]     <= r_win[3*y + 1];
                        r_win[3*y + 1] <= r_win[3*y + 2];
                    end
                    r_win[2] <= w_ram_rdata[LS_W-1:PIX_W];
                    r_win[5] <= w_ram_rdata[PIX_W-1:0];
                    r_win[8] <= r_px;
                    r_k      <= '0;
                    r_acc    <= '0;
                    r_tot    <= '0;
                    r_state  <= r_interior ? ST_MAC : ST_IDLE;
                end
                ST_MAC: begin
                    r_acc <= n_acc;
                    r_tot <= n_tot;
                    r_k   <= r_k + TAP_W'(1);
                    if (r_k == TAP_LAST) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_res   <= w_div_rsp.value;
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_out_last  <= r_last_col;
                        r_out_user  <= r_last_col && r_last_row;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous pixel still in flight");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider result outside divide phase");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_k <= TAP_LAST))
        else $error("tap counter out of range");

    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end without row end");

endmodule

### hw/rtl/ncc_ram.sv
module ncc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ncc_div.sv
module ncc_div
    import ncc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic             r_neg;
    logic [PIX_W-1:0] r_value;

    logic [ACC_W-1:0] w_mag_a;
    logic [TOT_W-1:0] w_mag_d;
    logic [PIX_W-1:0] w_raw_clamp;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W+1:0] w_trial;
    logic             w_fits;
    logic [DVS_W-1:0] n_rem;
    logic [QUO_W-1:0] n_quo;
    logic [PIX_W-1:0] w_quo_clamp;

    assign w_mag_a = i_req.acc[ACC_W-1] ? ACC_W'(-i_req.acc) : ACC_W'(i_req.acc);
    assign w_mag_d = i_req.total[TOT_W-1] ? TOT_W'(-i_req.total) : TOT_W'(i_req.total);

    // zero weight sum: clamp the raw sum
    assign w_raw_clamp = i_req.acc[ACC_W-1] ? '0 :
                         (|i_req.acc[ACC_W-2:PIX_W]) ? PIX_MAX : i_req.acc[PIX_W-1:0];

    // one restoring step per cycle
    assign w_shift = {r_rem, r_quo[QUO_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_fits  = !w_trial[DVS_W+1];
    assign n_rem   = w_fits ? w_trial[DVS_W-1:0] : w_shift[DVS_W-1:0];
    assign n_quo   = {r_quo[QUO_W-2:0], w_fits};

    assign w_quo_clamp = r_neg ? '0 :
                         (|n_quo[QUO_W-1:PIX_W]) ? PIX_MAX : n_quo[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.total == '0) begin
                    r_value <= w_raw_clamp;
                    r_done  <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(QUO_W - 1);
                    r_rem  <= '0;
                    r_quo  <= w_mag_a[QUO_W-1:0];
                    r_dvs  <= w_mag_d[DVS_W-1:0];
                    r_neg  <= i_req.acc[ACC_W-1] ^ i_req.total[TOT_W-1];
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_value <= w_quo_clamp;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule
